// ----- rtl/core/ste_pkg.sv -----
// Shared types, character codes and helpers for the s-expression tokenizer.
// Depends on nothing; the tokenizer and the testbench refer to it by scoped names.
package ste_pkg;

  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_TICK   = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_NUL    = 8'h00;

  localparam logic [1:0] KIND_PUNCT  = 2'd0;
  localparam logic [1:0] KIND_STRING = 2'd1;
  localparam logic [1:0] KIND_ATOM   = 2'd2;

  // Result queue geometry.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_ATOM   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [7:0] token_byte;
    logic       token_first;
    logic       token_last;
    logic [1:0] token_kind;
    logic       run_last;
  } token_t;

  function automatic logic is_blank(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

endpackage

// ----- rtl/core/ste_if.sv -----
// Valid/ready channel interfaces for the tokenizer's text input and token output.
// Depends on nothing; the payload widths are fixed by the field definitions.
interface ste_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface ste_token_if;
  logic       valid;
  logic       ready;
  logic [7:0] token_byte;
  logic       token_first;
  logic       token_last;
  logic [1:0] token_kind;
  logic       run_last;

  modport source (output valid, output token_byte, output token_first,
                  output token_last, output token_kind, output run_last, input ready);
  modport sink   (input valid, input token_byte, input token_first,
                  input token_last, input token_kind, input run_last, output ready);
endinterface

// ----- rtl/core/s_expression_tokenizer.sv -----
// S-expression tokenizer: one text byte in per cycle while the queue has room, token bytes out with marks and kind.
// Token bytes are registered in the result queue before they reach the output.
// Throughput: one text byte per cycle; a byte that yields two token bytes needs two output
// transactions, absorbed by a 4-entry queue that holds off the input only while it has three or more.
// Reset (synchronous, active high) returns to scanning between tokens and empties the queue.
// Depends on ste_pkg and the channel interfaces in ste_if.sv.
module s_expression_tokenizer (
  input  logic              clk,
  input  logic              rst,
  ste_text_if.sink          text,
  ste_token_if.source       token
);

  // Scanner state. A string or atom byte is held back one transaction so that
  // the byte after it can decide whether it carries the last mark.
  ste_pkg::mode_t scan_mode, scan_mode_next;
  logic           held_valid, held_valid_next;
  logic [7:0]     held_byte, held_byte_next;
  logic           held_first, held_first_next;

  // Result queue: written with up to two token bytes per input transaction,
  // read one entry per output transaction.
  ste_pkg::token_t                queue [ste_pkg::QUEUE_DEPTH];
  logic [ste_pkg::QPTR_W-1:0]     wr_ptr, rd_ptr;
  logic [ste_pkg::QCNT_W-1:0]     count;

  logic accept, pop;
  logic [7:0] c;
  logic       eot;

  // Per-byte decisions before the end-of-text flush is applied.
  ste_pkg::mode_t mid_mode;
  logic           mid_hv, mid_hf;
  logic [7:0]     mid_hb;
  logic           g_v, g_last;     // give the previously held byte
  logic [1:0]     g_kind;
  logic           p_v, p_first;    // pass the current byte straight through
  logic [1:0]     p_kind;
  logic           e_v;             // flush of the held byte at end of text
  logic [1:0]     e_kind;

  ste_pkg::token_t g_tok, p_tok, e_tok, r0, r1;
  logic [1:0]      num_res;

  assign c      = text.text_byte;
  assign eot    = text.end_of_text;
  // Room for the two results a single byte may cause, regardless of a pop.
  assign text.ready = (count <= ste_pkg::QCNT_W'(ste_pkg::QUEUE_DEPTH - 2));
  assign accept = text.valid && text.ready;
  assign pop    = token.valid && token.ready;

  // Scan decision for the incoming byte.
  always_comb begin
    mid_mode = scan_mode;
    mid_hv   = held_valid;
    mid_hb   = held_byte;
    mid_hf   = held_first;
    g_v      = 1'b0;
    g_last   = 1'b0;
    g_kind   = ste_pkg::KIND_ATOM;
    p_v      = 1'b0;
    p_first  = 1'b0;
    p_kind   = ste_pkg::KIND_PUNCT;
    case (scan_mode)
      ste_pkg::MODE_STRING: begin
        g_v    = held_valid;
        g_kind = ste_pkg::KIND_STRING;
        if (c == ste_pkg::CH_DQUOTE) begin
          // Closing quote: it ends the string itself.
          p_v      = 1'b1;
          p_kind   = ste_pkg::KIND_STRING;
          mid_hv   = 1'b0;
          mid_hf   = 1'b0;
          mid_mode = ste_pkg::MODE_IDLE;
        end else if (c == ste_pkg::CH_NUL) begin
          g_last   = 1'b1;
          mid_hv   = 1'b0;
          mid_hf   = 1'b0;
          mid_mode = ste_pkg::MODE_IDLE;
        end else begin
          mid_hv = 1'b1;
          mid_hb = c;
          mid_hf = 1'b0;
        end
      end
      ste_pkg::MODE_ATOM: begin
        g_v    = held_valid;
        g_kind = ste_pkg::KIND_ATOM;
        if (ste_pkg::is_blank(c) || (c == ste_pkg::CH_NUL)) begin
          g_last   = 1'b1;
          mid_hv   = 1'b0;
          mid_hf   = 1'b0;
          mid_mode = ste_pkg::MODE_IDLE;
        end else if (c == ste_pkg::CH_CLOSE) begin
          // The closing parenthesis ends the atom and follows as its own token.
          g_last   = 1'b1;
          p_v      = 1'b1;
          p_first  = 1'b1;
          p_kind   = ste_pkg::KIND_PUNCT;
          mid_hv   = 1'b0;
          mid_hf   = 1'b0;
          mid_mode = ste_pkg::MODE_IDLE;
        end else begin
          mid_hv = 1'b1;
          mid_hb = c;
          mid_hf = 1'b0;
        end
      end
      default: begin
        // Between tokens; an unused mode code behaves the same way.
        mid_mode = ste_pkg::MODE_IDLE;
        if ((c == ste_pkg::CH_OPEN) || (c == ste_pkg::CH_CLOSE) ||
            (c == ste_pkg::CH_TICK)) begin
          p_v     = 1'b1;
          p_first = 1'b1;
          p_kind  = ste_pkg::KIND_PUNCT;
        end else if (c == ste_pkg::CH_DQUOTE) begin
          mid_hv   = 1'b1;
          mid_hb   = c;
          mid_hf   = 1'b1;
          mid_mode = ste_pkg::MODE_STRING;
        end else if (!ste_pkg::is_blank(c) && (c != ste_pkg::CH_NUL)) begin
          mid_hv   = 1'b1;
          mid_hb   = c;
          mid_hf   = 1'b1;
          mid_mode = ste_pkg::MODE_ATOM;
        end
      end
    endcase
  end

  // Next state: the end-of-text flag flushes whatever is still held and
  // starts the next text between tokens.
  always_comb begin
    scan_mode_next  = mid_mode;
    held_valid_next = mid_hv;
    held_byte_next  = mid_hb;
    held_first_next = mid_hf;
    if (eot) begin
      scan_mode_next  = ste_pkg::MODE_IDLE;
      held_valid_next = 1'b0;
      held_first_next = 1'b0;
    end
  end

  // Result assembly: up to two of the three candidate token bytes, in order
  // held byte, current byte, end-of-text flush.
  always_comb begin
    e_v    = eot && mid_hv;
    e_kind = (mid_mode == ste_pkg::MODE_STRING) ? ste_pkg::KIND_STRING : ste_pkg::KIND_ATOM;

    g_tok = '{token_byte: held_byte, token_first: held_first, token_last: g_last,
              token_kind: g_kind, run_last: 1'b0};
    p_tok = '{token_byte: c, token_first: p_first, token_last: 1'b1,
              token_kind: p_kind, run_last: 1'b0};
    e_tok = '{token_byte: mid_hb, token_first: mid_hf, token_last: 1'b1,
              token_kind: e_kind, run_last: 1'b0};

    num_res = 2'({1'b0, g_v} + {1'b0, p_v} + {1'b0, e_v});

    if (g_v)      r0 = g_tok;
    else if (p_v) r0 = p_tok;
    else          r0 = e_tok;

    if (g_v && p_v) r1 = p_tok;
    else            r1 = e_tok;

    r0.run_last = (num_res == 2'd1);
    r1.run_last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode  <= ste_pkg::MODE_IDLE;
      held_valid <= 1'b0;
      held_byte  <= 8'd0;
      held_first <= 1'b0;
    end else if (accept) begin
      scan_mode  <= scan_mode_next;
      held_valid <= held_valid_next;
      held_byte  <= held_byte_next;
      held_first <= held_first_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + ste_pkg::QPTR_W'(num_res);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + ste_pkg::QPTR_W'(1);
      end
      count <= count + (accept ? ste_pkg::QCNT_W'(num_res) : '0)
                     - ste_pkg::QCNT_W'(pop);
    end
  end

  // Queue payload needs no reset; entries are read only once written.
  always_ff @(posedge clk) begin
    if (accept && (num_res != 2'd0)) begin
      queue[wr_ptr] <= r0;
    end
    if (accept && (num_res == 2'd2)) begin
      queue[wr_ptr + ste_pkg::QPTR_W'(1)] <= r1;
    end
  end

  assign token.valid       = (count != '0);
  assign token.token_byte  = queue[rd_ptr].token_byte;
  assign token.token_first = queue[rd_ptr].token_first;
  assign token.token_last  = queue[rd_ptr].token_last;
  assign token.token_kind  = queue[rd_ptr].token_kind;
  assign token.run_last    = queue[rd_ptr].run_last;

`ifndef ASSERT_OFF
  // A byte is held back exactly while a string or atom is open.
  a_held_matches_mode: assert property (@(posedge clk) disable iff (rst)
    held_valid == (scan_mode != ste_pkg::MODE_IDLE))
    else $error("held byte out of step with scan mode");

  // End of text always leaves the scanner empty and between tokens.
  a_eot_flushes: assert property (@(posedge clk) disable iff (rst)
    (accept && eot) |=> (!held_valid && (scan_mode == ste_pkg::MODE_IDLE)))
    else $error("end of text did not flush the held byte");

  // The queue never overfills.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ste_pkg::QCNT_W'(ste_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  // No byte causes more than two results.
  a_two_results: assert property (@(posedge clk) disable iff (rst)
    accept |-> !(g_v && p_v && e_v))
    else $error("more than two results from one byte");

  // A token byte always carries a defined kind.
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    token.valid |-> (token.token_kind != 2'd3))
    else $error("undefined token kind");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the s-expression tokenizer: directed and random text in,
// token bytes checked against an in-bench prediction of the scanner.
// Depends on ste_pkg, the channel interfaces in ste_if.sv and s_expression_tokenizer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Slowest correct run: about 1550 bytes, each with a random sender gap and up to two token
  // bytes that may each wait out a sink stall. That stays far below this ceiling, so it only
  // trips on a hang.
  localparam int CYCLE_LIMIT  = 400000;
  // Idle time after the last expected token lets any stray output show up before the verdict.
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 100;

  logic clk = 1'b0;
  logic rst;

  ste_text_if  text_ch ();
  ste_token_if token_ch ();

  s_expression_tokenizer u_dut (
    .clk   (clk),
    .rst   (rst),
    .text  (text_ch),
    .token (token_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Scanner prediction. This is the testbench's own copy of the tokenizer state: the scan
  // mode, and the one byte of a string or atom that is held back until we know whether it
  // ends its token.
  // ---------------------------------------------------------------------------------------
  ste_pkg::mode_t scan_state;
  logic           held_pending;
  logic [7:0]     held_char;
  logic           held_opens;

  // Token bytes caused by the current text byte, and the ordered store of token bytes that
  // the block still owes us.
  ste_pkg::token_t step_tokens[$];
  ste_pkg::token_t expected_tokens[$];

  int error_count    = 0;
  int cycle_count    = 0;
  int bytes_sent     = 0;
  int tokens_checked = 0;

  // Idle rates in percent, per transaction opportunity, for the text sender and token sink.
  int send_idle_pct = 0;
  int sink_idle_pct = 0;
  int stall_left    = 0;

  function automatic logic blank_char(input logic [7:0] c);
    return ((c >= 8'd9) && (c <= 8'd13)) || (c == 8'd32);
  endfunction

  function automatic ste_pkg::token_t make_token(input logic [7:0] b, input logic first,
                                                 input logic last, input logic [1:0] kind);
    ste_pkg::token_t t;
    t.token_byte  = b;
    t.token_first = first;
    t.token_last  = last;
    t.token_kind  = kind;
    t.run_last    = 1'b0;
    return t;
  endfunction

  // Emit the held-back byte, if there is one, with the given last mark and kind.
  task automatic flush_held(input logic last, input logic [1:0] kind);
    if (held_pending) begin
      step_tokens.push_back(make_token(held_char, held_opens, last, kind));
      held_pending = 1'b0;
      held_opens   = 1'b0;
    end
  endtask

  task automatic hold_char(input logic [7:0] c, input logic first);
    held_pending = 1'b1;
    held_char    = c;
    held_opens   = first;
  endtask

  // Advance the scanner by one accepted text byte and queue the token bytes it causes.
  task automatic predict_tokens(input logic [7:0] c, input logic eot);
    logic [1:0]      eot_kind;
    ste_pkg::token_t last_tok;
    step_tokens.delete();
    case (scan_state)
      ste_pkg::MODE_STRING: begin
        if (c == ste_pkg::CH_DQUOTE) begin
          // The closing quote belongs to the string and ends it.
          flush_held(1'b0, ste_pkg::KIND_STRING);
          step_tokens.push_back(make_token(c, 1'b0, 1'b1, ste_pkg::KIND_STRING));
          scan_state = ste_pkg::MODE_IDLE;
        end else if (c == ste_pkg::CH_NUL) begin
          // A nul cuts the string short; the held byte becomes its last byte.
          flush_held(1'b1, ste_pkg::KIND_STRING);
          scan_state = ste_pkg::MODE_IDLE;
        end else begin
          flush_held(1'b0, ste_pkg::KIND_STRING);
          hold_char(c, 1'b0);
        end
      end
      ste_pkg::MODE_ATOM: begin
        if (blank_char(c) || (c == ste_pkg::CH_NUL)) begin
          flush_held(1'b1, ste_pkg::KIND_ATOM);
          scan_state = ste_pkg::MODE_IDLE;
        end else if (c == ste_pkg::CH_CLOSE) begin
          // The closing paren ends the atom and then stands as a token of its own.
          flush_held(1'b1, ste_pkg::KIND_ATOM);
          step_tokens.push_back(make_token(c, 1'b1, 1'b1, ste_pkg::KIND_PUNCT));
          scan_state = ste_pkg::MODE_IDLE;
        end else begin
          flush_held(1'b0, ste_pkg::KIND_ATOM);
          hold_char(c, 1'b0);
        end
      end
      default: begin
        scan_state = ste_pkg::MODE_IDLE;
        if ((c == ste_pkg::CH_OPEN) || (c == ste_pkg::CH_CLOSE) ||
            (c == ste_pkg::CH_TICK)) begin
          step_tokens.push_back(make_token(c, 1'b1, 1'b1, ste_pkg::KIND_PUNCT));
        end else if (c == ste_pkg::CH_DQUOTE) begin
          hold_char(c, 1'b1);
          scan_state = ste_pkg::MODE_STRING;
        end else if (!blank_char(c) && (c != ste_pkg::CH_NUL)) begin
          hold_char(c, 1'b1);
          scan_state = ste_pkg::MODE_ATOM;
        end
      end
    endcase

    // End of text closes whatever token is open, string or atom alike.
    if (eot) begin
      eot_kind = (scan_state == ste_pkg::MODE_STRING) ? ste_pkg::KIND_STRING
                                                      : ste_pkg::KIND_ATOM;
      flush_held(1'b1, eot_kind);
      scan_state = ste_pkg::MODE_IDLE;
    end

    if (step_tokens.size() > 0) begin
      last_tok = step_tokens.pop_back();
      last_tok.run_last = 1'b1;
      step_tokens.push_back(last_tok);
    end
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endtask

  // ---------------------------------------------------------------------------------------
  // Checking. Every token transaction is compared with the oldest pending expectation.
  // ---------------------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int want, input int got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("tb: mismatch in %s at token transaction %0d: expected %0h, got %0h",
               what, tokens_checked, want, got);
  endtask

  always @(posedge clk) begin : token_check
    ste_pkg::token_t want;
    if (!rst && token_ch.valid && token_ch.ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch("token_byte, nothing pending", 0, int'(token_ch.token_byte));
      end else begin
        want = expected_tokens.pop_front();
        if (token_ch.token_byte !== want.token_byte)
          report_mismatch("token_byte", int'(want.token_byte), int'(token_ch.token_byte));
        if (token_ch.token_first !== want.token_first)
          report_mismatch("token_first", int'(want.token_first),
                          int'(token_ch.token_first));
        if (token_ch.token_last !== want.token_last)
          report_mismatch("token_last", int'(want.token_last), int'(token_ch.token_last));
        if (token_ch.token_kind !== want.token_kind)
          report_mismatch("token_kind", int'(want.token_kind), int'(token_ch.token_kind));
        if (token_ch.run_last !== want.run_last)
          report_mismatch("run_last", int'(want.run_last), int'(token_ch.run_last));
      end
      tokens_checked++;
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Token sink. Ready drops in random bursts at the current idle rate.
  // ---------------------------------------------------------------------------------------
  always @(negedge clk) begin
    if (stall_left > 0) begin
      token_ch.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if ($urandom_range(0, 99) < sink_idle_pct) begin
      token_ch.ready <= 1'b0;
      stall_left     <= $urandom_range(0, 13);
    end else begin
      token_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Text sender. Inputs change at the falling edge; the transaction is taken at the rising
  // edge where valid and ready are both high, and only then does the prediction advance.
  // Valid stays high from one byte to the next unless an idle burst is drawn.
  // ---------------------------------------------------------------------------------------
  task automatic send_text(input logic [7:0] b, input logic eot);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 14);
    @(negedge clk);
    if (gap > 0) begin
      text_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_ch.valid       <= 1'b1;
    text_ch.text_byte   <= b;
    text_ch.end_of_text <= eot;
    do @(posedge clk); while (!text_ch.ready);
    predict_tokens(b, eot);
    bytes_sent++;
  endtask

  // Random traffic ends the text now and then, on whatever byte comes up.
  task automatic send_char(input logic [7:0] b);
    send_text(b, $urandom_range(0, 39) == 0);
  endtask

  // Hold the sender off until the block has delivered everything it owes.
  task automatic wait_for_tokens();
    @(negedge clk);
    text_ch.valid <= 1'b0;
    while (expected_tokens.size() > 0) @(posedge clk);
  endtask

  // A byte that continues an atom; a leading byte must also not open another token.
  function automatic logic [7:0] atom_char(input logic leading);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (blank_char(c) || (c == ste_pkg::CH_CLOSE) ||
               (leading && ((c == ste_pkg::CH_OPEN) || (c == ste_pkg::CH_TICK) ||
                            (c == ste_pkg::CH_DQUOTE))));
    return c;
  endfunction

  function automatic logic [7:0] string_char();
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(1, 255));
    end while (c == ste_pkg::CH_DQUOTE);
    return c;
  endfunction

  function automatic logic [7:0] blank_pick();
    int n;
    n = $urandom_range(9, 14);
    return (n == 14) ? 8'd32 : 8'(n);
  endfunction

  task automatic send_atom();
    int len;
    len = $urandom_range(1, 6);
    send_char(atom_char(1'b1));
    repeat (len - 1) send_char(atom_char(1'b0));
  endtask

  // Mostly closed strings; now and then the quote is left open and the scan runs on.
  task automatic send_string();
    int len;
    len = $urandom_range(0, 8);
    send_char(ste_pkg::CH_DQUOTE);
    repeat (len) send_char(string_char());
    if ($urandom_range(0, 7) != 0) send_char(ste_pkg::CH_DQUOTE);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------------------

  // The three one-byte tokens.
  task automatic test_punctuation();
    send_text(ste_pkg::CH_OPEN, 1'b0);
    send_text(ste_pkg::CH_TICK, 1'b0);
    send_text(ste_pkg::CH_CLOSE, 1'b0);
  endtask

  // A closed string with the top byte value inside it, then a string cut short by a nul.
  task automatic test_strings();
    send_text(ste_pkg::CH_DQUOTE, 1'b0);
    send_text("a", 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(ste_pkg::CH_DQUOTE, 1'b0);
    send_text(ste_pkg::CH_DQUOTE, 1'b0);
    send_text("b", 1'b0);
    send_text(ste_pkg::CH_NUL, 1'b0);
  endtask

  // Atoms ended by a space, by a closing paren, by a nul and by end of text.
  task automatic test_atoms();
    send_text("x", 1'b0);
    send_text(8'd32, 1'b0);
    send_text("y", 1'b0);
    send_text("z", 1'b0);
    send_text(ste_pkg::CH_CLOSE, 1'b0);
    send_text(8'hFF, 1'b0);
    send_text(ste_pkg::CH_NUL, 1'b0);
    send_text("q", 1'b1);
  endtask

  // An unterminated string at end of text, end of text on a blank between tokens, a fresh
  // text right after, and a nul between tokens that must vanish.
  task automatic test_end_of_text();
    send_text(ste_pkg::CH_DQUOTE, 1'b0);
    send_text("k", 1'b1);
    send_text(8'd9, 1'b1);
    send_text("m", 1'b0);
    send_text(8'd13, 1'b0);
    send_text(ste_pkg::CH_NUL, 1'b0);
  endtask

  // Pile up two-byte results against a mostly stalled sink, then stop sending until the
  // block has drained completely.
  task automatic test_pause_for_tokens();
    send_idle_pct = 0;
    sink_idle_pct = 70;
    repeat (4) begin
      send_text("a", 1'b0);
      send_text(ste_pkg::CH_CLOSE, 1'b0);
    end
    wait_for_tokens();
  endtask

  // Random s-expression text: mostly well-formed tokens with random content, plus noise
  // bytes over the whole range and the odd nul.
  task automatic test_random_text(input int n_bytes, input int send_pct, input int sink_pct);
    int start;
    send_idle_pct = send_pct;
    sink_idle_pct = sink_pct;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      case ($urandom_range(0, 11))
        0, 1: send_char(ste_pkg::CH_OPEN);
        2, 3: send_char(ste_pkg::CH_CLOSE);
        4:    send_char(ste_pkg::CH_TICK);
        5, 6: begin
          send_atom();
          send_char(blank_pick());
        end
        7:    send_string();
        8:    repeat ($urandom_range(1, 3)) send_char(blank_pick());
        9: begin
          send_atom();
          send_char(ste_pkg::CH_CLOSE);
        end
        10:   send_char(8'($urandom_range(0, 255)));
        default: send_char(ste_pkg::CH_NUL);
      endcase
    end
  endtask

  initial begin
    text_ch.valid       = 1'b0;
    text_ch.text_byte   = '0;
    text_ch.end_of_text = 1'b0;
    token_ch.ready      = 1'b0;
    rst                 = 1'b1;
    scan_state          = ste_pkg::MODE_IDLE;
    held_pending        = 1'b0;
    held_char           = '0;
    held_opens          = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 20;
    sink_idle_pct = 20;
    test_punctuation();
    test_strings();
    test_atoms();
    test_end_of_text();
    test_pause_for_tokens();

    // Moderate idling, heavy sink stalls to fill the result queue, then a stretch that runs
    // flat out on both sides to close the run.
    test_random_text(600, 30, 30);
    test_random_text(500, 10, 60);
    test_random_text(400, 0, 0);

    wait_for_tokens();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ste_pkg.sv
rtl/core/ste_if.sv
rtl/core/s_expression_tokenizer.sv
tb/tb.sv
